[design/csq_pkg.sv]
`timescale 1ns / 1ps

package csq_pkg;

	// fixed field widths
	localparam int DATA_W = 32;
	localparam int RES_W  = 33;
	localparam int MUL_W  = 2 * RES_W;
	localparam int ACC_W  = 64;
	localparam int WIDE_W = MUL_W + 32;
	localparam int VL_W   = 7;

	localparam logic [VL_W-1:0] VL_RESET = 7'd1;

	// kind of input word, carried on tuser
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_ENTRY = 1'b1;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// step strobes from the sequencer to the index logic
	typedef struct packed {
		logic load;
		logic entry;
		logic advance;
	} csq_step_t;

	typedef struct packed {
		logic                    ovf;
		logic signed [ACC_W-1:0] val;
	} sat_t;

	// clamp a wide signed value into the 64-bit range
	function automatic sat_t sat_wide(input logic signed [WIDE_W-1:0] x);
		sat_t                     r;
		logic [WIDE_W-ACC_W:0]    top_bits;
		top_bits = x[WIDE_W-1:ACC_W-1];
		if ((&top_bits) || !(|top_bits)) begin
			r.ovf = 1'b0;
			r.val = x[ACC_W-1:0];
		end else begin
			r.ovf = 1'b1;
			r.val = x[WIDE_W-1] ? ACC_MIN : ACC_MAX;
		end
		return r;
	endfunction

endpackage

[design/csq_residual_mem.sv]
`timescale 1ns / 1ps

module csq_residual_mem
	import csq_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic signed [RES_W-1:0] wdata,
	input  logic                    re,
	input  logic [AW-1:0]           raddr_a,
	input  logic [AW-1:0]           raddr_b,
	output logic signed [RES_W-1:0] rdata_a,
	output logic signed [RES_W-1:0] rdata_b
);

	logic signed [RES_W-1:0] mem [DEPTH];

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

[design/csq_index_ctrl.sv]
`timescale 1ns / 1ps

module csq_index_ctrl
	import csq_pkg::*;
#(
	parameter int MAX_POINTS = 64,
	parameter int AW         = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [VL_W-1:0]         cfg_wdata,
	input  csq_step_t               step,
	input  logic signed [DATA_W-1:0] data_value,
	input  logic signed [DATA_W-1:0] model_value,
	output logic                    mem_we,
	output logic [AW-1:0]           mem_waddr,
	output logic signed [RES_W-1:0] mem_wdata,
	output logic                    mem_re,
	output logic [AW-1:0]           mem_raddr_a,
	output logic [AW-1:0]           mem_raddr_b,
	output logic                    pass_end
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int NW    = (CNT_W > VL_W) ? CNT_W : VL_W;

	logic [VL_W-1:0] vl_q;
	logic [NW-1:0]   load_idx_q;
	logic [NW-1:0]   row_q;
	logic [NW-1:0]   col_q;

	logic [NW-1:0]   vl_ext;
	logic [NW-1:0]   n_eff;
	logic [NW-1:0]   row_c;
	logic [NW-1:0]   col_c;
	logic [NW:0]     row_nx;
	logic [NW:0]     col_nx;
	logic            row_wrap;
	logic            col_wrap;

	// effective length, clamped to one .. MAX_POINTS
	always_comb begin
		vl_ext = NW'(vl_q);
		priority if (vl_ext == '0) begin
			n_eff = NW'(1);
		end else if (vl_ext > NW'(MAX_POINTS)) begin
			n_eff = NW'(MAX_POINTS);
		end else begin
			n_eff = vl_ext;
		end
	end

	// residual write on a load word
	assign mem_we    = step.load && (load_idx_q < n_eff);
	assign mem_waddr = load_idx_q[AW-1:0];
	assign mem_wdata = {data_value[DATA_W-1], data_value}
		- {model_value[DATA_W-1], model_value};

	// counters past a shrunken length read as the last point
	assign row_c       = (row_q >= n_eff) ? (n_eff - NW'(1)) : row_q;
	assign col_c       = (col_q >= n_eff) ? (n_eff - NW'(1)) : col_q;
	assign mem_re      = step.entry;
	assign mem_raddr_a = row_c[AW-1:0];
	assign mem_raddr_b = col_c[AW-1:0];

	// end of row and end of pass tests
	assign col_nx   = {1'b0, col_q} + (NW+1)'(1);
	assign row_nx   = {1'b0, row_q} + (NW+1)'(1);
	assign col_wrap = col_nx >= {1'b0, n_eff};
	assign row_wrap = row_nx >= {1'b0, n_eff};
	assign pass_end = col_wrap && row_wrap;

	// length register and index counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_q       <= VL_RESET;
			load_idx_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
		end else begin
			if (cfg_we) begin
				vl_q <= cfg_wdata;
			end
			if (mem_we) begin
				load_idx_q <= load_idx_q + NW'(1);
			end
			if (step.advance) begin
				if (!col_wrap) begin
					col_q <= col_nx[NW-1:0];
				end else begin
					col_q <= '0;
					if (row_wrap) begin
						row_q      <= '0;
						load_idx_q <= '0;
					end else begin
						row_q <= row_nx[NW-1:0];
					end
				end
			end
		end
	end

	// a load and a counter step never share a cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		!(step.load && step.advance))
		else $error("load and advance in the same cycle");

	// the row and column counters hold unless a counter step or a length write comes
	assert property (@(posedge clk) disable iff (!arst_n)
		(!step.advance && !cfg_we) |=> $stable(row_q) && $stable(col_q))
		else $error("index counters moved without a step");

	// completed pass leaves all counters at zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(step.advance && pass_end) |=> (row_q == '0 && col_q == '0 && load_idx_q == '0))
		else $error("counters not cleared after a pass");

endmodule

[design/csq_mac_engine.sv]
`timescale 1ns / 1ps

module csq_mac_engine
	import csq_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_action,
	input  logic signed [DATA_W-1:0] in_entry,
	output logic                     in_ready,
	input  logic signed [RES_W-1:0]  rd_a,
	input  logic signed [RES_W-1:0]  rd_b,
	input  logic                     pass_end,
	output csq_step_t                step,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [ACC_W-1:0]  out_chi,
	output logic                     out_ovf
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_SAT1,
		ST_MULLO,
		ST_MULHI,
		ST_SUM,
		ST_ACC,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic                     out_valid_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     ovf_seen_q;
	logic signed [DATA_W-1:0] m_q;
	logic signed [MUL_W-1:0]  prod_q;
	logic signed [MUL_W-1:0]  hi_q;
	logic signed [ACC_W-1:0]  t_q;
	logic signed [ACC_W-1:0]  p_q;
	logic signed [ACC_W-1:0]  chi_q;
	logic                     ovf_q;

	logic                     accept;
	logic                     out_free;
	logic signed [RES_W-1:0]  mul_a;
	logic signed [RES_W-1:0]  mul_b;
	logic signed [MUL_W-1:0]  mul_p;
	logic signed [MUL_W-1:0]  t_sh;
	logic signed [WIDE_W-1:0] t_wide;
	logic signed [WIDE_W-1:0] p_full;
	logic signed [WIDE_W-1:0] p_sh;
	logic signed [ACC_W:0]    acc_sum;
	sat_t                     t_sat;
	sat_t                     p_sat;
	logic                     acc_ovf;
	logic signed [ACC_W-1:0]  acc_nx;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_chi   = chi_q;
	assign out_ovf   = ovf_q;

	assign step.load    = accept && (in_action == ACT_LOAD);
	assign step.entry   = accept && (in_action == ACT_ENTRY);
	assign step.advance = (state_q == ST_ACC);

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_MUL1: begin
				mul_a = rd_a;
				mul_b = rd_b;
			end
			ST_MULLO: begin
				mul_a = $signed({1'b0, t_q[31:0]});
				mul_b = $signed({m_q[DATA_W-1], m_q});
			end
			default: begin
				mul_a = $signed({t_q[ACC_W-1], t_q[ACC_W-1:32]});
				mul_b = $signed({m_q[DATA_W-1], m_q});
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// residual product, floored and clamped
	assign t_sh   = prod_q >>> FRACTION_BITS;
	assign t_wide = {{(WIDE_W-MUL_W){t_sh[MUL_W-1]}}, t_sh};
	assign t_sat  = sat_wide(t_wide);

	// recombine the two partial products of t times the entry
	assign p_full = $signed({hi_q, 32'd0})
		+ $signed({{(WIDE_W-MUL_W){prod_q[MUL_W-1]}}, prod_q});
	assign p_sh   = p_full >>> FRACTION_BITS;
	assign p_sat  = sat_wide(p_sh);

	// saturating accumulate
	assign acc_sum = {acc_q[ACC_W-1], acc_q} + {p_q[ACC_W-1], p_q};
	assign acc_ovf = acc_sum[ACC_W] != acc_sum[ACC_W-1];
	assign acc_nx  = !acc_ovf ? acc_sum[ACC_W-1:0]
		: (acc_sum[ACC_W] ? ACC_MIN : ACC_MAX);

	// sequencer, accumulator and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			ovf_seen_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (step.entry) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_SAT1;
				ST_SAT1: begin
					ovf_seen_q <= ovf_seen_q | t_sat.ovf;
					state_q    <= ST_MULLO;
				end
				ST_MULLO: state_q <= ST_MULHI;
				ST_MULHI: state_q <= ST_SUM;
				ST_SUM: begin
					ovf_seen_q <= ovf_seen_q | p_sat.ovf;
					state_q    <= ST_ACC;
				end
				ST_ACC: begin
					acc_q      <= acc_nx;
					ovf_seen_q <= ovf_seen_q | acc_ovf;
					state_q    <= pass_end ? ST_DONE : ST_IDLE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						acc_q       <= '0;
						ovf_seen_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// datapath and result word registers
	always_ff @(posedge clk) begin
		if (step.entry) begin
			m_q <= in_entry;
		end
		if (state_q == ST_MUL1 || state_q == ST_MULLO) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_MULHI) begin
			hi_q <= mul_p;
		end
		if (state_q == ST_SAT1) begin
			t_q <= t_sat.val;
		end
		if (state_q == ST_SUM) begin
			p_q <= p_sat.val;
		end
		if (state_q == ST_DONE && out_free) begin
			chi_q <= acc_q;
			ovf_q <= ovf_seen_q;
		end
	end

	// an entry word always starts the multiply chain
	assert property (@(posedge clk) disable iff (!arst_n)
		step.entry |=> (state_q == ST_MUL1))
		else $error("entry word did not start the multiply chain");

	// counter step leads to idle or to the result
	assert property (@(posedge clk) disable iff (!arst_n)
		step.advance |=> (state_q == ST_IDLE || state_q == ST_DONE))
		else $error("unexpected state after accumulate");

	// a new result word only comes out of the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	// done waits while the previous word is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !out_ready) |=> (state_q == ST_DONE))
		else $error("result overwritten while stalled");

endmodule

[design/chi_square_quadratic_form_top.sv]
`timescale 1ns / 1ps
// channel     | direction | handshake                    | payload
// ------------+-----------+------------------------------+----------------------------------
// s_axis      | in        | s_axis_tvalid/s_axis_tready  | tdata: data, model, entry; tuser: action
// m_axis      | out       | m_axis_tvalid/m_axis_tready  | tdata: chi_square; tuser: overflow
// cfg         | in        | cfg_we                       | cfg_wdata: vector_length
//
// a load word writes its residual to the store at once
// a matrix word steps the sequencer through MUL1, SAT1, MULLO, MULHI, SUM and ACC,
// sharing one 33x33 multiplier over three products; the residual store read is registered
// the last matrix word of a pass also goes through the done state, which moves the sum to the output
// reset clears the counters, accumulator and length (to one); residuals stay undefined
// a stalled result holds in the output register; further words are still taken
// until the next pass completes

module chi_square_quadratic_form_top
	import csq_pkg::*;
#(
	parameter int MAX_POINTS    = 64,
	parameter int FRACTION_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [VL_W-1:0] cfg_wdata,       // vector_length
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [95:0]     s_axis_tdata,    // data_value, model_value, matrix_entry
	input  logic            s_axis_tuser,    // action
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [63:0]     m_axis_tdata,    // chi_square
	output logic            m_axis_tuser     // overflow
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	csq_step_t               step;
	logic                    pass_end;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic signed [RES_W-1:0] mem_wdata;
	logic                    mem_re;
	logic [AW-1:0]           mem_raddr_a;
	logic [AW-1:0]           mem_raddr_b;
	logic signed [RES_W-1:0] rd_a;
	logic signed [RES_W-1:0] rd_b;
	logic signed [ACC_W-1:0] chi;

	// index counters and length register
	csq_index_ctrl #(
		.MAX_POINTS (MAX_POINTS),
		.AW         (AW)
	) u_index (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.step        (step),
		.data_value  ($signed(s_axis_tdata[31:0])),
		.model_value ($signed(s_axis_tdata[63:32])),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr_a (mem_raddr_a),
		.mem_raddr_b (mem_raddr_b),
		.pass_end    (pass_end)
	);

	// residual store
	csq_residual_mem #(
		.DEPTH (MAX_POINTS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// multiply-accumulate sequencer
	csq_mac_engine #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_action (s_axis_tuser),
		.in_entry  ($signed(s_axis_tdata[95:64])),
		.in_ready  (s_axis_tready),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.pass_end  (pass_end),
		.step      (step),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_chi   (chi),
		.out_ovf   (m_axis_tuser)
	);

	assign m_axis_tdata = chi;

endmodule
